### hdl/halton_sequence_generator_assert.svh
// Assertion macros for the Halton sequence generator.
// Self-contained; taken in by `include where assertions are written.
`ifndef HALTON_SEQUENCE_GENERATOR_ASSERT_SVH
`define HALTON_SEQUENCE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define HSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("halton_sequence_generator: check failed");

// Next-cycle implication, disabled while reset is held
`define HSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("halton_sequence_generator: check failed");

`endif

### hdl/hsg_pkg.sv
// Package for the Halton sequence generator: fixed field widths, prime base
// table and the status struct of the advance unit. No dependencies.
`default_nettype none

package hsg_pkg;

    localparam int DIM_W   = 4;
    localparam int BASE_W  = 6;
    localparam int STEPS_W = 8;
    localparam int CFG_W   = 5;

    typedef logic [BASE_W-1:0] base_t;

    // first sixteen primes, ascending
    localparam base_t PRIMES [16] = '{
        6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19,
        6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
    };

    typedef struct packed {
        logic busy;
        logic done;
    } adv_stat_t;

endpackage

`default_nettype wire

### hdl/hsg_adv.sv
// Advance unit: steps one dimension's fraction through the radical-inverse
// sequence with one shared fraction-by-base multiplier. Depends on hsg_pkg.
`default_nettype none

module hsg_adv #(
    parameter int FRACTION_WIDTH = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [hsg_pkg::STEPS_W-1:0]   steps,
    input  wire hsg_pkg::base_t                base,
    input  wire logic [FRACTION_WIDTH-1:0]     numer_in,
    input  wire logic [FRACTION_WIDTH-1:0]     denom_in,
    input  wire logic                          ovf_in,
    output hsg_pkg::adv_stat_t                 stat,
    output logic [FRACTION_WIDTH-1:0]          numer_out,
    output logic [FRACTION_WIDTH-1:0]          denom_out,
    output logic                               ovf_out
);

    localparam int FW = FRACTION_WIDTH;
    localparam int PW = FRACTION_WIDTH + hsg_pkg::BASE_W;

    typedef enum logic [1:0] {A_IDLE, A_STEP, A_POW} state_t;

    state_t                        state_reg, state_next;
    logic [FW-1:0]                 n_reg, n_next;
    logic [FW-1:0]                 d_reg, d_next;
    logic [FW-1:0]                 y_reg, y_next;
    logic [FW-1:0]                 x_reg, x_next;
    logic                          ovf_reg, ovf_next;
    logic [hsg_pkg::STEPS_W-1:0]   cnt_reg, cnt_next;
    hsg_pkg::base_t                base_reg, base_next;
    logic                          done_reg, done_next;

    logic [FW-1:0] mul_a;
    logic [PW-1:0] prod;
    logic [FW-1:0] diff;
    logic          n_ge_d;
    logic          prod_ovf;
    logic          pow_done;
    logic [FW-1:0] new_n;

    // shared multiplier: denominator on a wrap step, power of base otherwise
    assign mul_a    = (state_reg == A_POW) ? y_reg : d_reg;
    assign prod     = PW'(mul_a) * PW'(base_reg);
    assign diff     = d_reg - n_reg;
    assign n_ge_d   = (n_reg >= d_reg);
    assign prod_ovf = |prod[PW-1:FW];
    assign pow_done = (prod >= PW'(x_reg));
    assign new_n    = prod[FW-1:0] + y_reg - x_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        y_next     = y_reg;
        x_next     = x_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    n_next     = numer_in;
                    d_next     = denom_in;
                    ovf_next   = ovf_in;
                    cnt_next   = steps;
                    base_next  = base;
                    state_next = A_STEP;
                end
            end
            A_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else if (ovf_reg || n_ge_d)
                begin
                    // frozen dimension: drop the remaining steps
                    cnt_next = '0;
                end
                else if (diff == FW'(1))
                begin
                    if (prod_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        n_next   = FW'(1);
                        d_next   = prod[FW-1:0];
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    y_next     = FW'(1);
                    x_next     = diff;
                    state_next = A_POW;
                end
            end
            A_POW:
            begin
                // y ends as the largest power of the base below x
                if (pow_done)
                begin
                    n_next     = new_n;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = A_STEP;
                end
                else
                begin
                    y_next = prod[FW-1:0];
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            n_reg     <= '0;
            d_reg     <= FW'(1);
            y_reg     <= '0;
            x_reg     <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            d_reg     <= d_next;
            y_reg     <= y_next;
            x_reg     <= x_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            done_reg  <= done_next;
        end
    end

    assign stat.busy = (state_reg != A_IDLE);
    assign stat.done = done_reg;
    assign numer_out = n_reg;
    assign denom_out = d_reg;
    assign ovf_out   = ovf_reg;

endmodule

`default_nettype wire

### hdl/halton_sequence_generator.sv
// Top level of the incremental Halton sequence generator: per-dimension
// fraction store, dimension sequencer and result register.
// Depends on hsg_pkg, hsg_adv and halton_sequence_generator_assert.svh.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  request   start, busy               steps, restart
//  result    strobe (one cycle)        dim_index, numer, denom, overflow, last
//  config    cfg_wr_en                 cfg_wr_data (active dimension count)
//
// A request is a transfer at a clock edge with start high and busy low.
// Each active dimension is loaded, advanced and written back in turn; on a
// denominator wrap an advance takes a single multiply, otherwise it first
// raises a power of the base up to the largest one below d - n. The shared
// multiplier in hsg_adv sets the pace. Each dimension also passes through
// load, finish and write-back; then one result per cycle, one per dimension.
// Reset clears all fractions to 0/1, all overflow flags and sets 16 dimensions.
// Results cannot be stalled: each stands on the ports for one cycle only.
`default_nettype none
`include "halton_sequence_generator_assert.svh"

module halton_sequence_generator #(
    parameter int MAX_DIMS       = 16,
    parameter int FRACTION_WIDTH = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [hsg_pkg::STEPS_W-1:0]   steps,
    input  wire logic                          restart,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [hsg_pkg::CFG_W-1:0]     cfg_wr_data,
    // result
    output logic                               strobe,
    output logic [hsg_pkg::DIM_W-1:0]          dim_index,
    output logic [FRACTION_WIDTH-1:0]          numer,
    output logic [FRACTION_WIDTH-1:0]          denom,
    output logic                               overflow,
    output logic                               last
);

    localparam int FW    = FRACTION_WIDTH;
    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DW    = hsg_pkg::DIM_W;
    localparam int CW    = hsg_pkg::CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_EMIT} state_t;

    // per-dimension fraction store
    logic [FW-1:0] numer_mem [MAX_DIMS];
    logic [FW-1:0] denom_mem [MAX_DIMS];
    logic          ovf_mem   [MAX_DIMS];

    logic [hsg_pkg::CFG_W-1:0] dims_reg;

    state_t          state_reg;
    logic [DW-1:0]   dim_reg;
    logic [DW-1:0]   last_dim_reg;
    logic [hsg_pkg::STEPS_W-1:0] steps_reg;
    logic            strobe_reg;
    logic [DW-1:0]   dim_index_reg;
    logic [FW-1:0]   numer_reg;
    logic [FW-1:0]   denom_reg;
    logic            overflow_reg;
    logic            last_reg;

    logic               accept;
    logic [DW-1:0]      active_m1;
    logic [IDX_W-1:0]   idx;
    logic               adv_start;
    logic               wb_en;
    hsg_pkg::adv_stat_t adv_stat;
    logic [FW-1:0]      adv_numer;
    logic [FW-1:0]      adv_denom;
    logic               adv_ovf;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign idx       = dim_reg[IDX_W-1:0];
    assign adv_start = (state_reg == S_LOAD);
    assign wb_en     = (state_reg == S_WAIT) && adv_stat.done;

    // clamp the active count into 1..MAX_DIMS, held as the highest index
    always_comb
    begin
        if (dims_reg == '0)
        begin
            active_m1 = '0;
        end
        else if (dims_reg > CW'(MAX_DIMS))
        begin
            active_m1 = DW'(MAX_DIMS - 1);
        end
        else
        begin
            active_m1 = DW'(dims_reg - 1'b1);
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= CW'(16);
        end
        else if (cfg_wr_en)
        begin
            dims_reg <= cfg_wr_data;
        end
    end

    // fraction store: restart clears every dimension, active or not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                numer_mem[i] <= '0;
                denom_mem[i] <= FW'(1);
                ovf_mem[i]   <= 1'b0;
            end
        end
        else if (accept && restart)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                numer_mem[i] <= '0;
                denom_mem[i] <= FW'(1);
                ovf_mem[i]   <= 1'b0;
            end
        end
        else if (wb_en)
        begin
            numer_mem[idx] <= adv_numer;
            denom_mem[idx] <= adv_denom;
            ovf_mem[idx]   <= adv_ovf;
        end
    end

    hsg_adv #(
        .FRACTION_WIDTH (FRACTION_WIDTH)
    ) u_adv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (adv_start),
        .steps     (steps_reg),
        .base      (hsg_pkg::PRIMES[dim_reg]),
        .numer_in  (numer_mem[idx]),
        .denom_in  (denom_mem[idx]),
        .ovf_in    (ovf_mem[idx]),
        .stat      (adv_stat),
        .numer_out (adv_numer),
        .denom_out (adv_denom),
        .ovf_out   (adv_ovf)
    );

    // dimension sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dim_reg       <= '0;
            last_dim_reg  <= '0;
            steps_reg     <= '0;
            strobe_reg    <= 1'b0;
            dim_index_reg <= '0;
            numer_reg     <= '0;
            denom_reg     <= '0;
            overflow_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // hold the request and the active count for the whole walk
                        steps_reg    <= steps;
                        last_dim_reg <= active_m1;
                        dim_reg      <= '0;
                        state_reg    <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (adv_stat.done)
                    begin
                        if (dim_reg == last_dim_reg)
                        begin
                            dim_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            dim_reg   <= dim_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_EMIT:
                begin
                    // one result per cycle, ascending dimension order
                    strobe_reg    <= 1'b1;
                    dim_index_reg <= dim_reg;
                    numer_reg     <= numer_mem[idx];
                    denom_reg     <= denom_mem[idx];
                    overflow_reg  <= ovf_mem[idx];
                    last_reg      <= (dim_reg == last_dim_reg);
                    if (dim_reg == last_dim_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        dim_reg <= dim_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign dim_index = dim_index_reg;
    assign numer     = numer_reg;
    assign denom     = denom_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;

    // the final result of a request is never directly followed by another
    `HSG_ASSERT_NEXT(a_last_gap, clk, rst_n, strobe && last, !strobe)
    // the advance unit is only started when it is free
    `HSG_ASSERT_IMPLY(a_adv_free, clk, rst_n, adv_start, !adv_stat.busy)
    // a written-back denominator is never zero
    `HSG_ASSERT_IMPLY(a_denom_nz, clk, rst_n, wb_en, adv_denom != '0)
    // results stay within the active dimensions of the request
    `HSG_ASSERT_IMPLY(a_dim_range, clk, rst_n, strobe, dim_index <= last_dim_reg)

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for halton_sequence_generator: directed table, then random phases.
// Depends on hsg_pkg and the generator RTL; needs no files or arguments at run time.
`timescale 1ns / 1ps

module testbench;

    localparam int          DIM_W       = hsg_pkg::DIM_W;
    localparam int          STEPS_W     = hsg_pkg::STEPS_W;
    localparam int          CFG_W       = hsg_pkg::CFG_W;
    localparam int          NDIMS       = 16;
    localparam int          FRAC_W      = 48;
    localparam logic [63:0] FRAC_MAX    = (64'd1 << FRAC_W) - 64'd1;
    localparam longint      CYCLE_LIMIT = 40_000_000;
    localparam int          N_DIRECTED  = 18;
    localparam int          N_PHASES    = 12;
    localparam int          PHASE_ITEMS = 37;

    // radix of each dimension, dimension 0 in the low byte
    localparam logic [15:0][7:0] RADIX = {
        8'd53, 8'd47, 8'd43, 8'd41, 8'd37, 8'd31, 8'd29, 8'd23,
        8'd19, 8'd17, 8'd13, 8'd11, 8'd7,  8'd5,  8'd3,  8'd2
    };

    // how a directed row is checked: against the predictor, or against
    // values typed in here (every point at 0/1, or every point at 1/base)
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ORIGIN,
        CHK_FIRST
    } row_check_e;

    typedef struct packed {
        logic               wr_cfg;
        logic [CFG_W-1:0]   dims;
        logic [STEPS_W-1:0] nsteps;
        logic               rst_frac;
        row_check_e         chk;
    } dir_row_t;

    typedef struct packed {
        logic [DIM_W-1:0]  dim;
        logic [FRAC_W-1:0] numer;
        logic [FRAC_W-1:0] denom;
        logic              ovf;
        logic              last;
    } coord_t;

    // Directed rows. Fraction overflow needs more advances than the run can
    // afford (base 53 only wraps past 53^8), so it is left to the predictor.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b0, 5'd0,  8'd0,   1'b0, CHK_ORIGIN},  // state straight after reset
        '{1'b0, 5'd0,  8'd1,   1'b0, CHK_FIRST},   // first advance gives 1/base
        '{1'b0, 5'd0,  8'd1,   1'b0, CHK_MODEL},
        '{1'b0, 5'd0,  8'd255, 1'b0, CHK_MODEL},   // longest stride
        '{1'b0, 5'd0,  8'd0,   1'b1, CHK_ORIGIN},  // restart without stepping
        '{1'b0, 5'd0,  8'd1,   1'b1, CHK_FIRST},
        '{1'b1, 5'd0,  8'd5,   1'b0, CHK_MODEL},   // zero dimensions acts as one
        '{1'b1, 5'd1,  8'd255, 1'b0, CHK_MODEL},
        '{1'b1, 5'd31, 8'd3,   1'b0, CHK_MODEL},   // above the top acts as sixteen
        '{1'b1, 5'd17, 8'd0,   1'b1, CHK_ORIGIN},
        '{1'b1, 5'd16, 8'd128, 1'b0, CHK_MODEL},
        '{1'b1, 5'd8,  8'd170, 1'b1, CHK_MODEL},
        '{1'b1, 5'd16, 8'd85,  1'b0, CHK_MODEL},   // idle dimensions kept their state
        '{1'b1, 5'd2,  8'd255, 1'b1, CHK_MODEL},
        '{1'b1, 5'd15, 8'd1,   1'b1, CHK_FIRST},
        '{1'b1, 5'd16, 8'd0,   1'b0, CHK_MODEL},
        '{1'b1, 5'd1,  8'd0,   1'b1, CHK_ORIGIN},  // restart reaches idle dimensions
        '{1'b1, 5'd16, 8'd0,   1'b0, CHK_ORIGIN}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [STEPS_W-1:0]     steps;
    logic                   restart;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   strobe;
    logic [DIM_W-1:0]       dim_index;
    logic [FRAC_W-1:0]      numer;
    logic [FRAC_W-1:0]      denom;
    logic                   overflow;
    logic                   last;

    // predictor state: one exact fraction per dimension plus its sticky wrap flag
    logic [63:0]            frac_num [NDIMS];
    logic [63:0]            frac_den [NDIMS];
    logic                   wrap_flag [NDIMS];
    logic [CFG_W-1:0]       dims_reg;

    coord_t                 coord_expect_q [$];
    int                     mismatch_count = 0;
    longint                 cycle_count = 0;

    halton_sequence_generator #(
        .MAX_DIMS       (NDIMS),
        .FRACTION_WIDTH (FRAC_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .steps       (steps),
        .restart     (restart),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .strobe      (strobe),
        .dim_index   (dim_index),
        .numer       (numer),
        .denom       (denom),
        .overflow    (overflow),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // clamp the dimension register to the range the block honours
    function automatic int active_dims();
        if (dims_reg == 0)
            return 1;
        if (dims_reg > NDIMS)
            return NDIMS;
        return int'(dims_reg);
    endfunction

    // one step of the radical inverse in the dimension's base
    task automatic advance_fraction(input int i);
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] y;
        p = 64'(RADIX[i]);
        n = frac_num[i];
        d = frac_den[i];
        if (wrap_flag[i] || n >= d)
            return;
        x = d - n;
        if (x == 64'd1)
        begin
            // next digit position: grow the denominator unless it would wrap
            if (d > FRAC_MAX / p)
                wrap_flag[i] = 1'b1;
            else
            begin
                frac_num[i] = 64'd1;
                frac_den[i] = d * p;
            end
        end
        else
        begin
            y = d / p;
            while (y >= x)
                y = y / p;
            frac_num[i] = ((p + 64'd1) * y - x) & FRAC_MAX;
        end
    endtask

    task automatic clear_fractions();
        for (int i = 0; i < NDIMS; i++)
        begin
            frac_num[i]  = 64'd0;
            frac_den[i]  = 64'd1;
            wrap_flag[i] = 1'b0;
        end
    endtask

    // advance the point for one request and queue the coordinates it emits
    task automatic predict_point(input logic [STEPS_W-1:0] nsteps, input logic rst_frac);
        int     act;
        coord_t c;
        act = active_dims();
        if (rst_frac)
            clear_fractions();
        for (int i = 0; i < act; i++)
            for (int s = 0; s < int'(nsteps); s++)
                advance_fraction(i);
        for (int i = 0; i < act; i++)
        begin
            c.dim   = DIM_W'(i);
            c.numer = frac_num[i][FRAC_W-1:0];
            c.denom = frac_den[i][FRAC_W-1:0];
            c.ovf   = wrap_flag[i];
            c.last  = (i + 1 == act);
            coord_expect_q.insert(coord_expect_q.size(), c);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: sample at the rising edge, compare with the oldest
    // expected coordinate field by field
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_coords
        coord_t want;
        if (rst_n && strobe)
        begin
            if (coord_expect_q.size() == 0)
            begin
                $error("unexpected result transfer for dimension %0d", dim_index);
                mismatch_count++;
            end
            else
            begin
                want = coord_expect_q.pop_front();
                if (dim_index !== want.dim)
                begin
                    $error("dim_index: expected %0d, got %0d", want.dim, dim_index);
                    mismatch_count++;
                end
                if (numer !== want.numer)
                begin
                    $error("numer (dim %0d): expected %0d, got %0d", want.dim, want.numer, numer);
                    mismatch_count++;
                end
                if (denom !== want.denom)
                begin
                    $error("denom (dim %0d): expected %0d, got %0d", want.dim, want.denom, denom);
                    mismatch_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow (dim %0d): expected %0d, got %0d", want.dim, want.ovf,
                           overflow);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last (dim %0d): expected %0d, got %0d", want.dim, want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Hold start high after a gap of idle cycles and wait for the transfer;
    // predict at the edge that takes the request. Typed rows then overwrite
    // the fraction fields of the coordinates just queued.
    task automatic send_request(input logic [STEPS_W-1:0] nsteps, input logic rst_frac,
                                input int gap, input row_check_e chk);
        int act;
        int idx;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        steps   <= nsteps;
        restart <= rst_frac;
        do
            @(posedge clk);
        while (busy);
        act = active_dims();
        predict_point(nsteps, rst_frac);
        if (chk != CHK_MODEL)
            for (int k = 0; k < act; k++)
            begin
                idx = coord_expect_q.size() - act + k;
                coord_expect_q[idx].numer = (chk == CHK_FIRST) ? 48'd1 : 48'd0;
                coord_expect_q[idx].denom = (chk == CHK_FIRST) ? 48'(RADIX[k]) : 48'd1;
                coord_expect_q[idx].ovf   = 1'b0;
            end
    endtask

    // write the dimension count once the block has drained every result
    task automatic write_dims(input logic [CFG_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (coord_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dims_reg = value;
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0]   dims_v;
        logic [STEPS_W-1:0] st;
        logic               rs;
        int                 pick;
        int                 burst;
        int                 gap;

        // drive every input to a known value from time zero
        rst_n       = 1'b0;
        start       = 1'b0;
        steps       = '0;
        restart     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        clear_fractions();
        dims_reg = CFG_W'(NDIMS);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int row = 0; row < N_DIRECTED; row++)
        begin
            if (DIRECTED[row].wr_cfg)
                write_dims(DIRECTED[row].dims);
            send_request(DIRECTED[row].nsteps, DIRECTED[row].rst_frac,
                         $urandom_range(0, 8), DIRECTED[row].chk);
        end

        // Random phases: each opens with a new dimension count, the first few
        // at the extremes. Most strides are short to keep the run brief; a few
        // reach the top of the field. Some phases send back to back.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:       dims_v = 5'd31;
                1:       dims_v = 5'd0;
                2:       dims_v = 5'd16;
                3:       dims_v = 5'd1;
                default: dims_v = CFG_W'($urandom_range(0, 31));
            endcase
            write_dims(dims_v);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    st = STEPS_W'($urandom_range(128, 255));
                else if (pick < 15)
                    st = STEPS_W'($urandom_range(16, 63));
                else
                    st = STEPS_W'($urandom_range(0, 15));
                rs  = ($urandom_range(0, 9) == 0);
                gap = burst ? 0 : $urandom_range(0, 8);
                send_request(st, rs, gap, CHK_MODEL);
            end
        end

        // drain, then give the block time to show any stray result
        @(negedge clk);
        start <= 1'b0;
        while (coord_expect_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS halton_sequence_generator");
        else
            $display("FAIL halton_sequence_generator");
        $finish;
    end

    // watchdog: stop a hung run well past the slowest legal pace
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL halton_sequence_generator");
        $finish;
    end

endmodule
